[src/ajkm_pkg.sv]
// ----------------------------------------------------------------------------
// ajkm_pkg
// Shared sizes, types and helpers of the keyed as-of join block.
// ----------------------------------------------------------------------------
package ajkm_pkg;

    // number of right tables held in the memo, and key slots per table
    localparam int RIGHT_TABLES = 4;
    localparam int KEY_SLOTS    = 4096;

    // probes report on at most four tables
    localparam int MAX_RESULTS  = 4;
    localparam int PROBE_LIMIT  = (RIGHT_TABLES < MAX_RESULTS) ? RIGHT_TABLES : MAX_RESULTS;

    // memo geometry
    localparam int MEMO_DEPTH   = RIGHT_TABLES * KEY_SLOTS;
    localparam int MEMO_AW      = (MEMO_DEPTH > 1) ? $clog2(MEMO_DEPTH) : 1;

    // fixed field widths
    localparam int KEY_W   = 12;
    localparam int TIME_W  = 64;
    localparam int REF_W   = 32;
    localparam int TBL_W   = 2;
    localparam int TOL_W   = 63;
    localparam int ACT_W   = 3;
    localparam int CFG_DW  = 64;
    localparam int CFG_AW  = 4;

    // input function codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_PROBE = 1'b1;

    // register indexes
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_ACTIVE    = 1'b1;

    // reset value of the active table count
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 3'd4;

    // one memo entry
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] etime;
        logic [REF_W-1:0]  row_ref;
    } t_memo_word;

    // memo access request from the sequencer
    typedef struct packed {
        logic               wr_en;
        logic [MEMO_AW-1:0] wr_addr;
        t_memo_word         wr_data;
        logic               rd_en;
        logic [MEMO_AW-1:0] rd_addr;
    } t_memo_req;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [TOL_W-1:0] tolerance;
        logic [ACT_W-1:0] active;
    } t_cfg;

    // sequencer status
    typedef struct packed {
        logic clearing;
        logic busy;
    } t_seq_status;

    // number of tables that one probe reports on
    function automatic logic [ACT_W-1:0] probe_count(input logic [ACT_W-1:0] active);
        logic [ACT_W-1:0] lim;
        lim = ACT_W'(PROBE_LIMIT);
        if (active == '0) begin
            return ACT_W'(1);
        end else if (active > lim) begin
            return lim;
        end
        return active;
    endfunction

endpackage

[src/ajkm_memo.sv]
// ----------------------------------------------------------------------------
// ajkm_memo
// Single-port-write, single-port-read memo store with registered read data.
// ----------------------------------------------------------------------------
module ajkm_memo
    import ajkm_pkg::*;
(
    input  logic       i_clk,
    input  t_memo_req  i_req,
    output t_memo_word o_rd_data
);

    t_memo_word r_mem [MEMO_DEPTH];
    t_memo_word r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/ajkm_tolcmp.sv]
// ----------------------------------------------------------------------------
// ajkm_tolcmp
// Shared tolerance compare: entry time plus tolerance against left time.
// ----------------------------------------------------------------------------
module ajkm_tolcmp
    import ajkm_pkg::*;
(
    input  logic [TIME_W-1:0] i_entry_time,
    input  logic [TOL_W-1:0]  i_tolerance,
    input  logic [TIME_W-1:0] i_left_time,
    output logic              o_hit
);

    logic [TIME_W:0] sum;

    // sum carries one extra bit so it never wraps
    assign sum   = {1'b0, i_entry_time} + {2'b00, i_tolerance};
    assign o_hit = (sum >= {1'b0, i_left_time});

endmodule

[src/ajkm_seq.sv]
// ----------------------------------------------------------------------------
// ajkm_seq
// Sequencer: memo clearing pass, key wrap, store, and one probe per table.
// ----------------------------------------------------------------------------
module ajkm_seq
    import ajkm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_func,
    input  logic [TBL_W-1:0]  i_table_index,
    input  logic [KEY_W-1:0]  i_join_key,
    input  logic [TIME_W-1:0] i_event_time,
    input  logic [REF_W-1:0]  i_row_ref,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [REF_W-1:0]  o_probe_row_ref,
    output logic [TBL_W-1:0]  o_out_table,
    output logic              o_matched,
    output logic [REF_W-1:0]  o_match_row_ref,
    output logic              o_last,
    // memo
    output t_memo_req         o_memo_req,
    input  t_memo_word        i_memo_rd,
    output t_seq_status       o_status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_EVAL
    } t_state;

    t_state             r_state,   n_state;
    logic [MEMO_AW-1:0] r_clr_addr, n_clr_addr;
    logic               r_func,    n_func;
    logic [TBL_W-1:0]   r_table,   n_table;
    logic [KEY_W-1:0]   r_key,     n_key;
    logic [TIME_W-1:0]  r_time,    n_time;
    logic [REF_W-1:0]   r_ref,     n_ref;
    logic [ACT_W-1:0]   r_idx,     n_idx;
    logic [ACT_W-1:0]   r_count,   n_count;
    logic [MEMO_AW-1:0] r_base,    n_base;
    logic               r_out_valid,     n_out_valid;
    logic [REF_W-1:0]   r_probe_row_ref, n_probe_row_ref;
    logic [TBL_W-1:0]   r_out_table,     n_out_table;
    logic               r_matched,       n_matched;
    logic [REF_W-1:0]   r_match_row_ref, n_match_row_ref;
    logic               r_last,          n_last;

    logic      time_hit;
    logic      hit;
    logic      out_free;
    logic      key_over;
    logic      is_last;
    t_memo_req req;

    // shared compare unit, used once per probed table
    ajkm_tolcmp u_tolcmp (
        .i_entry_time (i_memo_rd.etime),
        .i_tolerance  (i_cfg.tolerance),
        .i_left_time  (r_time),
        .o_hit        (time_hit)
    );

    assign hit      = i_memo_rd.valid && time_hit;
    assign out_free = !r_out_valid || !i_out_stall;
    assign key_over = ({{(32-KEY_W){1'b0}}, r_key} >= 32'(KEY_SLOTS));
    assign is_last  = ((r_idx + ACT_W'(1)) == r_count);

    // next state and memo requests
    always_comb begin
        n_state         = r_state;
        n_clr_addr      = r_clr_addr;
        n_func          = r_func;
        n_table         = r_table;
        n_key           = r_key;
        n_time          = r_time;
        n_ref           = r_ref;
        n_idx           = r_idx;
        n_count         = r_count;
        n_base          = r_base;
        n_out_valid     = r_out_valid && i_out_stall;
        n_probe_row_ref = r_probe_row_ref;
        n_out_table     = r_out_table;
        n_matched       = r_matched;
        n_match_row_ref = r_match_row_ref;
        n_last          = r_last;
        req             = '0;

        unique case (r_state)
            S_CLEAR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_clr_addr;
                req.wr_data = '0;
                if (r_clr_addr == MEMO_AW'(MEMO_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + MEMO_AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_table = i_table_index;
                    n_key   = i_join_key;
                    n_time  = i_event_time;
                    n_ref   = i_row_ref;
                    n_count = probe_count(i_cfg.active);
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (key_over) begin
                    // wrap the key one slot span at a time
                    n_key = r_key - KEY_W'(KEY_SLOTS);
                end else if (r_func == FUNC_STORE) begin
                    if (32'(r_table) < 32'(RIGHT_TABLES)) begin
                        req.wr_en           = 1'b1;
                        req.wr_addr         = MEMO_AW'(r_table) * MEMO_AW'(KEY_SLOTS)
                                            + MEMO_AW'(r_key);
                        req.wr_data.valid   = 1'b1;
                        req.wr_data.etime   = r_time;
                        req.wr_data.row_ref = r_ref;
                    end
                    n_state = S_IDLE;
                end else begin
                    // start the probe at table 0
                    req.rd_en   = 1'b1;
                    req.rd_addr = MEMO_AW'(r_key);
                    n_base      = MEMO_AW'(r_key);
                    n_idx       = '0;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_probe_row_ref = r_ref;
                    n_out_table     = r_idx[TBL_W-1:0];
                    n_matched       = hit;
                    n_match_row_ref = hit ? i_memo_rd.row_ref : '0;
                    n_last          = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next table while this result goes out
                        n_idx       = r_idx + ACT_W'(1);
                        n_base      = r_base + MEMO_AW'(KEY_SLOTS);
                        req.rd_en   = 1'b1;
                        req.rd_addr = r_base + MEMO_AW'(KEY_SLOTS);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_func          <= n_func;
        r_table         <= n_table;
        r_key           <= n_key;
        r_time          <= n_time;
        r_ref           <= n_ref;
        r_idx           <= n_idx;
        r_count         <= n_count;
        r_base          <= n_base;
        r_probe_row_ref <= n_probe_row_ref;
        r_out_table     <= n_out_table;
        r_matched       <= n_matched;
        r_match_row_ref <= n_match_row_ref;
        r_last          <= n_last;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_probe_row_ref = r_probe_row_ref;
    assign o_out_table     = r_out_table;
    assign o_matched       = r_matched;
    assign o_match_row_ref = r_match_row_ref;
    assign o_last          = r_last;
    assign o_memo_req      = req;

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_status.busy     = (r_state != S_IDLE);

endmodule

[src/asof_join_keyed_memo.sv]
// ----------------------------------------------------------------------------
// asof_join_keyed_memo
// As-of join with tolerance over a keyed memo of right-table rows.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one row item: a store
// (func 0) writes the (table, key) memo entry, a probe (func 1) looks up the
// key in the active right tables, at least one and at most four. Output
// channel (o_out_valid / i_out_stall) gives one result item per probed
// table, table 0 first, last flagged. A store is written to the memo in
// the reduce state and the block then returns to idle. A probe first issues
// the memo read for table 0, then one result leaves per cycle while the
// receiver does not stall, set by the single memo read port feeding the
// shared tolerance compare. A 12-bit key never reaches the slot count.
// Results sit in an output register; while the receiver stalls, the probe
// waits on that register and resumes when it is taken.
// After reset the memo valid bits are cleared by a sweep over all MEMO_DEPTH
// entries (16384 as built), one entry per cycle; no item is accepted during
// the sweep, while configuration writes are taken as ever.
// Configuration: APB, 64-bit data, tolerance at 0x0, active tables at 0x8.
// ----------------------------------------------------------------------------
module asof_join_keyed_memo
    import ajkm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_func,
    input  logic [TBL_W-1:0]  i_table_index,
    input  logic [KEY_W-1:0]  i_join_key,
    input  logic [TIME_W-1:0] i_event_time,
    input  logic [REF_W-1:0]  i_row_ref,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [REF_W-1:0]  o_probe_row_ref,
    output logic [TBL_W-1:0]  o_out_table,
    output logic              o_matched,
    output logic [REF_W-1:0]  o_match_row_ref,
    output logic              o_last
);

    logic [TOL_W-1:0] r_tolerance;
    logic [ACT_W-1:0] r_active;
    logic             cfg_wr;
    logic             reg_sel;
    t_cfg             cfg;
    t_memo_req        memo_req;
    t_memo_word       memo_rd;
    t_seq_status      status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= '0;
            r_active    <= ACTIVE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TOLERANCE: r_tolerance <= pwdata[TOL_W-1:0];
                REG_ACTIVE:    r_active    <= pwdata[ACT_W-1:0];
                default:       r_active    <= r_active;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_sel)
            REG_TOLERANCE: prdata = {{(CFG_DW-TOL_W){1'b0}}, r_tolerance};
            REG_ACTIVE:    prdata = {{(CFG_DW-ACT_W){1'b0}}, r_active};
            default:       prdata = '0;
        endcase
    end

    assign cfg.tolerance = r_tolerance;
    assign cfg.active    = r_active;

    ajkm_memo u_memo (
        .i_clk     (i_clk),
        .i_req     (memo_req),
        .o_rd_data (memo_rd)
    );

    ajkm_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_table_index   (i_table_index),
        .i_join_key      (i_join_key),
        .i_event_time    (i_event_time),
        .i_row_ref       (i_row_ref),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_probe_row_ref (o_probe_row_ref),
        .o_out_table     (o_out_table),
        .o_matched       (o_matched),
        .o_match_row_ref (o_match_row_ref),
        .o_last          (o_last),
        .o_memo_req      (memo_req),
        .i_memo_rd       (memo_rd),
        .o_status        (status)
    );

    // no result while the memo is being cleared
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !o_out_valid)
        else $error("result item during memo clearing pass");

    // a probe stays busy while a result other than its last is waiting
    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> status.busy)
        else $error("probe ended before its last result");

    // an unmatched result carries a zero handle
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_matched) |-> (o_match_row_ref == '0))
        else $error("unmatched result with nonzero handle");

    // reported table stays inside the probe limit
    a_table_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_table) < 32'(PROBE_LIMIT)))
        else $error("result for a table beyond the probe limit");

endmodule
